// ===== src/ps2mq_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mq_pkg
// Shared types and constants for the PS/2 mouse packet queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mq_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam int OUTQ_DEPTH = 2;

  localparam int SYNC_BIT   = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;

  localparam logic [1:0] LAST_BYTE = 2'd2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_kind_t;

  // first field in the highest bits
  typedef struct packed {
    logic [9:0] move_y;
    logic [8:0] move_x;
    logic [2:0] buttons;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

  typedef struct packed {
    cmd_kind_t kind;
    event_t    ev;
  } cmd_t;

  typedef struct packed {
    logic   event_valid;
    event_t ev;
  } result_t;

  typedef struct packed {
    logic push;
    logic full;
  } cmdq_ctl_t;

endpackage

`default_nettype wire

// ===== src/ps2mq_ram.sv =====
// ----------------------------------------------------------------------------
// ps2mq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ps2mq_front.sv =====
// ----------------------------------------------------------------------------
// ps2mq_front
// Accepts input transactions, assembles mouse packets, emits commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mq_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic [1:0]        in_tuser,
  output      ps2mq_pkg::cmdq_ctl_t ctl,
  input  wire logic              cmdq_full,
  output      ps2mq_pkg::cmd_t   cmd
);

  logic [7:0] head_r, head_nxt;
  logic [7:0] dx_r, dx_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       is_read;
  logic [9:0] dy_ext;

  assign in_tready = !cmdq_full;
  assign accept    = in_tvalid && in_tready;
  assign is_read   = in_tuser[0];

  assign dy_ext = {{2{head_r[ps2mq_pkg::Y_SIGN_BIT]}}, in_tdata};

  always_comb begin
    head_nxt = head_r;
    dx_nxt   = dx_r;
    cnt_nxt  = cnt_r;
    ctl.push = 1'b0;
    ctl.full = cmdq_full;
    cmd.kind = is_read ? ps2mq_pkg::CMD_READ : ps2mq_pkg::CMD_PUSH;
    cmd.ev.buttons = head_r[2:0];
    cmd.ev.move_x  = {head_r[ps2mq_pkg::X_SIGN_BIT], dx_r};
    cmd.ev.move_y  = 10'd0 - dy_ext;
    if (accept) begin
      if (is_read) begin
        ctl.push = 1'b1;
      end else if (in_tuser[1]) begin
        unique case (cnt_r)
          2'd0: begin
            head_nxt = in_tdata;
            cnt_nxt  = 2'd1;
          end
          2'd1: begin
            dx_nxt  = in_tdata;
            cnt_nxt = ps2mq_pkg::LAST_BYTE;
          end
          default: begin
            cnt_nxt  = 2'd0;
            ctl.push = head_r[ps2mq_pkg::SYNC_BIT];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    dx_r   <= dx_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ps2mq_cmdq.sv =====
// ----------------------------------------------------------------------------
// ps2mq_cmdq
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mq_cmdq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ps2mq_pkg::cmdq_ctl_t ctl,
  input  wire ps2mq_pkg::cmd_t      wr_cmd,
  output      logic                 full,
  output      logic                 rd_valid,
  output      ps2mq_pkg::cmd_t      rd_cmd,
  input  wire logic                 pop
);

  ps2mq_pkg::cmd_t                 q_r [ps2mq_pkg::CMDQ_DEPTH];
  logic [ps2mq_pkg::CMDQ_AW-1:0]   wp_r;
  logic [ps2mq_pkg::CMDQ_AW-1:0]   rp_r;
  logic [ps2mq_pkg::CMDQ_AW:0]     cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign full     = (cnt_r == (ps2mq_pkg::CMDQ_AW+1)'(ps2mq_pkg::CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = q_r[rp_r];
  assign do_push  = ctl.push && !ctl.full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= wr_cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (ps2mq_pkg::CMDQ_AW+1)'(do_push)
                     - (ps2mq_pkg::CMDQ_AW+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/ps2mq_back.sv =====
// ----------------------------------------------------------------------------
// ps2mq_back
// Executes commands against the event ring and buffers read results.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mq_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire ps2mq_pkg::cmd_t   cmd,
  output      logic              cmd_pop,
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [23:0]       out_tdata,
  output      logic [0:0]        out_tuser
);

  localparam int AW = ps2mq_pkg::RING_AW;
  localparam logic [AW-1:0] LAST_IDX = AW'(ps2mq_pkg::RING_DEPTH - 1);

  logic [AW-1:0]             wr_r, rd_r, wr_inc, rd_inc;
  logic                      empty, full;
  logic                      do_write, do_read;
  logic                      pend_r, hit_r;
  logic [ps2mq_pkg::EVENT_W-1:0] ram_q;
  ps2mq_pkg::result_t        res;
  ps2mq_pkg::result_t        ob_r [ps2mq_pkg::OUTQ_DEPTH];
  ps2mq_pkg::result_t        ob_head;
  logic                      ob_wp_r, ob_rp_r;
  logic [1:0]                occ_r;
  logic                      out_pop;
  logic [2:0]                room;
  logic                      can_issue;

  assign wr_inc = (wr_r == LAST_IDX) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == LAST_IDX) ? '0 : rd_r + 1'b1;
  assign empty  = (wr_r == rd_r);
  assign full   = (wr_inc == rd_r);

  assign out_pop   = out_tvalid && out_tready;
  assign room      = {1'b0, occ_r} + {2'b0, pend_r} - {2'b0, out_pop};
  assign can_issue = (room < 3'(ps2mq_pkg::OUTQ_DEPTH));

  assign cmd_pop  = cmd_valid && ((cmd.kind == ps2mq_pkg::CMD_PUSH) || can_issue);
  assign do_write = cmd_pop && (cmd.kind == ps2mq_pkg::CMD_PUSH) && !full;
  assign do_read  = cmd_pop && (cmd.kind == ps2mq_pkg::CMD_READ);

  ps2mq_ram #(
    .WIDTH (ps2mq_pkg::EVENT_W),
    .DEPTH (ps2mq_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_r),
    .wdata (cmd.ev),
    .re    (do_read),
    .raddr (rd_r),
    .rdata (ram_q)
  );

  assign res.event_valid = hit_r;
  assign res.ev          = hit_r ? ps2mq_pkg::event_t'(ram_q) : '0;

  assign ob_head    = ob_r[ob_rp_r];
  assign out_tvalid = (occ_r != 2'd0);
  assign out_tdata  = {2'b00, ob_head.ev};
  assign out_tuser  = ob_head.event_valid;

  always_ff @(posedge clk) begin
    if (pend_r) begin
      ob_r[ob_wp_r] <= res;
    end
    if (do_read) begin
      hit_r <= !empty;
    end
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      pend_r  <= 1'b0;
      ob_wp_r <= 1'b0;
      ob_rp_r <= 1'b0;
      occ_r   <= 2'd0;
    end else begin
      if (do_write) begin
        wr_r <= wr_inc;
      end
      if (do_read && !empty) begin
        rd_r <= rd_inc;
      end
      pend_r <= do_read;
      if (pend_r) begin
        ob_wp_r <= !ob_wp_r;
      end
      if (out_pop) begin
        ob_rp_r <= !ob_rp_r;
      end
      occ_r <= room[1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/ps2_mouse_packet_queue_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_queue_unit
// PS/2 mouse packet decoder with an event queue.
//
// Input channel: in_tdata carries the controller byte; in_tuser[0] selects
// the transaction kind (0 = byte arrives, 1 = read one event) and
// in_tuser[1] marks a byte from the mouse port. Bytes assemble into
// three-byte packets; each good packet becomes an event in a ring of
// RING_DEPTH entries that holds up to RING_DEPTH-1 events.
// Output channel: every read request returns one transaction; out_tuser[0]
// is 1 when an event was popped, else the data is zero.
// Throughput is one input transaction per cycle while the command queue is
// not full. An accepted read request passes in order through the command
// queue, the ring RAM read and the output buffer.
// Reset empties the ring and the packet assembler; no clearing pass.
// When the receiver stalls, the two-entry output buffer and the command
// queue fill, then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte[7:0]
  input  wire logic [1:0]  in_tuser,   // func[0], from_aux[1]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // buttons[2:0], move_x[11:3], move_y[21:12]
  output      logic [0:0]  out_tuser   // event_valid[0]
);

  ps2mq_pkg::cmdq_ctl_t ctl;
  ps2mq_pkg::cmd_t      front_cmd;
  ps2mq_pkg::cmd_t      back_cmd;
  logic                 cmdq_full;
  logic                 cmd_valid;
  logic                 cmd_pop;

  ps2mq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ctl       (ctl),
    .cmdq_full (cmdq_full),
    .cmd       (front_cmd)
  );

  ps2mq_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_cmd   (front_cmd),
    .full     (cmdq_full),
    .rd_valid (cmd_valid),
    .rd_cmd   (back_cmd),
    .pop      (cmd_pop)
  );

  ps2mq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (back_cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> (in_tvalid && in_tready))
    else $error("command pushed without an accepted input");

  a_pop_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 24'd0))
    else $error("empty read result carries nonzero data");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== verif/ps2_mouse_packet_queue_unit_test.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_queue_unit_test
// Self-checking testbench for the PS/2 mouse packet queue. Directed tests
// cover empty reads, move extremes, bad sync packets and bytes from the
// wrong port. A ring fill and drain test and mixed random traffic follow,
// run with and without sender gaps and receiver stalls. Every read result
// is compared field by field against an in-order prediction.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte[7:0]
  logic [1:0]  in_tuser;   // func[0], from_aux[1]
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;  // buttons[2:0], move_x[11:3], move_y[21:12]
  logic [0:0]  out_tuser;  // event_valid[0]

  ps2_mouse_packet_queue_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state mirror
  logic [7:0]           pkt_hold [0:1];
  logic [1:0]           byte_cnt;
  ps2mq_pkg::event_t    queued_events [$];
  ps2mq_pkg::result_t   expected_reads [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int idle_cycles    = 0;
  int events_queued  = 0;
  int sync_drops     = 0;
  int full_drops     = 0;
  int reads_done     = 0;
  int empty_reads    = 0;

  function automatic void apply_transaction(input ps2mq_pkg::cmd_kind_t kind,
                                            input logic [7:0] data, input logic aux);
    ps2mq_pkg::event_t  ev;
    ps2mq_pkg::result_t res;
    if (kind == ps2mq_pkg::CMD_PUSH) begin
      if (!aux) return;
      if (byte_cnt < ps2mq_pkg::LAST_BYTE) begin
        pkt_hold[byte_cnt[0]] = data;
        byte_cnt = byte_cnt + 2'd1;
        return;
      end
      byte_cnt = 2'd0;
      if (!pkt_hold[0][ps2mq_pkg::SYNC_BIT]) begin
        sync_drops++;
        return;
      end
      ev.buttons = pkt_hold[0][2:0];
      ev.move_x  = {pkt_hold[0][ps2mq_pkg::X_SIGN_BIT], pkt_hold[1]};
      ev.move_y  = 10'd0 - {pkt_hold[0][ps2mq_pkg::Y_SIGN_BIT],
                            pkt_hold[0][ps2mq_pkg::Y_SIGN_BIT], data};
      if (queued_events.size() < ps2mq_pkg::RING_DEPTH - 1) begin
        queued_events.push_back(ev);
        events_queued++;
      end else begin
        full_drops++;
      end
    end else begin
      res = '0;
      reads_done++;
      if (queued_events.size() != 0) begin
        res.event_valid = 1'b1;
        res.ev = queued_events.pop_front();
      end else begin
        empty_reads++;
      end
      expected_reads.push_back(res);
    end
  endfunction

  // called at a falling edge, returns at a falling edge with in_tvalid still high
  task automatic send_item(input ps2mq_pkg::cmd_kind_t kind, input logic [7:0] data,
                           input logic aux);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= {aux, kind};
    do @(posedge clk); while (!in_tready);
    apply_transaction(kind, data, aux);
    @(negedge clk);
  endtask

  task automatic send_read();
    send_item(ps2mq_pkg::CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                             input logic [7:0] dy, input logic noise);
    send_item(ps2mq_pkg::CMD_PUSH, head, 1'b1);
    if (noise) send_item(ps2mq_pkg::CMD_PUSH, 8'($urandom_range(255)), 1'b0);
    send_item(ps2mq_pkg::CMD_PUSH, dx, 1'b1);
    send_item(ps2mq_pkg::CMD_PUSH, dy, 1'b1);
  endtask

  task automatic send_random_packet(input logic good);
    logic [7:0] head;
    head = 8'($urandom_range(255));
    head[ps2mq_pkg::SYNC_BIT] = good;
    send_packet(head, 8'($urandom_range(255)), 8'($urandom_range(255)),
                $urandom_range(9) == 0);
  endtask

  task automatic test_empty_read();
    send_read();
    send_read();
  endtask

  task automatic test_move_extremes();
    send_packet(8'h3f, 8'h00, 8'h00, 1'b0);  // x = -256, y = +256, all buttons
    send_packet(8'h08, 8'hff, 8'hff, 1'b0);  // x = +255, y = -255
    send_packet(8'h29, 8'h01, 8'hff, 1'b0);  // y sign set, y = +1
    repeat (4) send_read();
  endtask

  task automatic test_bad_sync_and_noise();
    send_item(ps2mq_pkg::CMD_PUSH, 8'hff, 1'b0);
    send_packet(8'hf7, 8'h55, 8'haa, 1'b0);  // sync bit clear, dropped
    send_packet(8'h0a, 8'h80, 8'h7f, 1'b1);  // mouse-port byte split by a keyboard byte
    send_item(ps2mq_pkg::CMD_PUSH, 8'h18, 1'b1);  // stray byte shifts the framing
    send_packet(8'h44, 8'h0c, 8'h99, 1'b0);
    repeat (3) send_read();
  endtask

  task automatic test_ring_fill_and_drain();
    repeat (ps2mq_pkg::RING_DEPTH + 6) send_random_packet(1'b1);
    repeat (ps2mq_pkg::RING_DEPTH + 2) send_read();
  endtask

  task automatic run_mixed_traffic(input int item_goal, input int read_pct);
    int sent;
    int pick;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < read_pct) begin
        send_read();
        sent++;
      end else if (pick < read_pct + 5) begin
        send_item(ps2mq_pkg::CMD_PUSH, 8'($urandom_range(255)), 1'b0);
      end else if (pick < read_pct + 8) begin
        send_item(ps2mq_pkg::CMD_PUSH, 8'($urandom_range(255)), 1'b1);
        sent++;
      end else begin
        send_random_packet($urandom_range(99) < 85);
        sent += 3;
      end
    end
  endtask

  task automatic test_traffic_phase(input int sender_pct, input int receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    run_mixed_traffic(75, 20);
    run_mixed_traffic(75, 50);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(input string what, input logic [9:0] want,
                                      input logic [9:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : read_checker
    ps2mq_pkg::result_t want;
    ps2mq_pkg::event_t  got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[ps2mq_pkg::EVENT_W-1:0];
      if (expected_reads.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h / %h", $time, out_tuser,
                 out_tdata);
        fail_count++;
      end else begin
        want = expected_reads.pop_front();
        check_field("event_valid", 10'(want.event_valid), 10'(out_tuser[0]));
        check_field("buttons", 10'(want.ev.buttons), 10'(got.buttons));
        check_field("move_x", 10'(want.ev.move_x), 10'(got.move_x));
        check_field("move_y", want.ev.move_y, got.move_y);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, expected_reads.size());
      $display("ps2_mouse_packet_queue_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    byte_cnt  = 2'd0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_read();
    test_move_extremes();
    test_bad_sync_and_noise();
    test_ring_fill_and_drain();
    test_traffic_phase(0, 0);
    test_traffic_phase(71, 0);
    test_traffic_phase(0, 71);
    test_traffic_phase(15, 15);

    in_tvalid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d queued events, %0d bad-sync packets, %0d ring-full drops,",
             events_queued, sync_drops, full_drops);
    $display("and %0d reads (%0d on an empty ring) under four stall/gap mixes.",
             reads_done, empty_reads);
    if (fail_count == 0) begin
      $display("ps2_mouse_packet_queue_unit regression: pass");
    end else begin
      $display("ps2_mouse_packet_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
